>>> rtl/spg_pkg.sv
// Shared types and constants for the step pulse generator.
// Used by spg_ctrl, spg_datapath, spg_checker and step_pulse_generator; no dependencies.
`timescale 1ns / 1ps

package spg_pkg;

  // Item codes on the mode field
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_RATE = 2'd1,
    MODE_STOP = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Timebase and position sizing
  localparam int SLOW_PRESCALE = 16;
  localparam int PRESC_W       = (SLOW_PRESCALE > 2) ? $clog2(SLOW_PRESCALE) : 1;
  localparam int POSITION_BITS = 32;

  // Field widths
  localparam int RATE_W   = 25;
  localparam int MAG_W    = 24;
  localparam int WHOLE_W  = 23;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = 17;
  localparam int WIDTH_W  = 4;
  localparam int OUT_POS_W = 32;
  localparam int PULSE_W  = 32;

  // Rate limits in millisteps per second
  localparam logic signed [RATE_W-1:0] RATE_LIMIT     = 25'sd10000000;
  localparam logic signed [RATE_W-1:0] RATE_LIMIT_NEG = -25'sd10000000;
  localparam logic [MAG_W-1:0] RATE_STOP_BELOW = 24'd50;
  localparam logic [MAG_W-1:0] RATE_SLOW_BELOW = 24'd1000;

  // Timebase clocks in ticks per second
  localparam longint unsigned CLK_FAST = 64'd5000000;
  localparam longint unsigned CLK_SLOW = CLK_FAST / SLOW_PRESCALE;

  // Pulse width in timebase ticks, at least two
  localparam longint unsigned WIDTH_FAST_RAW = (CLK_FAST + 64'd499999) / 64'd500000;
  localparam longint unsigned WIDTH_SLOW_RAW = (CLK_SLOW + 64'd499999) / 64'd500000;
  localparam logic [WIDTH_W-1:0] WIDTH_FAST =
    WIDTH_W'((WIDTH_FAST_RAW < 64'd2) ? 64'd2 : WIDTH_FAST_RAW);
  localparam logic [WIDTH_W-1:0] WIDTH_SLOW =
    WIDTH_W'((WIDTH_SLOW_RAW < 64'd2) ? 64'd2 : WIDTH_SLOW_RAW);

  // Divider: period = clk * 65536000 / |rate| in 1/65536-tick units
  localparam int DVD_W     = 49;
  localparam int QUOT_W    = WHOLE_W + FRAC_W;
  localparam logic [DVD_W-1:0] DVD_FAST = DVD_W'(CLK_FAST * 64'd65536000);
  localparam logic [DVD_W-1:0] DVD_SLOW = DVD_W'(CLK_SLOW * 64'd65536000);
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic apply_item;   // item applied without division: tick, stop, no-op, small rate
    logic start_div;    // latch a rate command and load the divider
    logic div_step;     // one quotient bit
    logic apply_rate;   // commit the divided rate
  } spg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rate_div;     // item on the input is a rate command that needs division
    logic div_last;     // divider is on its final bit
    logic out_free;     // output register can take a result this cycle
  } spg_status_t;

endpackage

>>> rtl/step_pulse_generator.sv
// A tick, stop, no-op or small-rate item gives its result in the output register in the cycle
// after it is taken; a rate command of |rate| >= 50 is committed after the divide and finish
// states. One tick, stop, no-op or small-rate item per cycle while the output is not stalled;
// a rate command holds the input while a restoring divider finds 49 quotient bits, one per cycle.
// Reset (rst_n low, synchronous) stops the timer, clears position and count, empties the output.
// Top level of the step pulse generator; depends on spg_pkg, spg_ctrl, spg_datapath.
`timescale 1ns / 1ps

module step_pulse_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic signed [spg_pkg::RATE_W-1:0]    in_rate_millisteps,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_step_level,
  output logic                                 out_direction_reverse,
  output logic signed [spg_pkg::OUT_POS_W-1:0] out_position_count,
  output logic [spg_pkg::PULSE_W-1:0]          out_total_pulses,
  output logic                                 out_running
);

  spg_pkg::spg_cmd_t    cmd;
  spg_pkg::spg_status_t status;

  // Sequencer
  spg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Timer, counters, divider and result register
  spg_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_mode               (in_mode),
    .in_rate_millisteps    (in_rate_millisteps),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_step_level        (out_step_level),
    .out_direction_reverse (out_direction_reverse),
    .out_position_count    (out_position_count),
    .out_total_pulses      (out_total_pulses),
    .out_running           (out_running)
  );

endmodule

>>> rtl/spg_ctrl.sv
// Sequencing controller for the step pulse generator.
// Depends on spg_pkg; drives spg_datapath through spg_cmd_t.
`timescale 1ns / 1ps

module spg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spg_pkg::spg_status_t status,
  output spg_pkg::spg_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // Input is taken only when idle and the result slot is free
  assign in_ready = (state_r == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  // Commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (status.rate_div) begin
            cmd.start_div = 1'b1;
            state_nxt     = ST_DIVIDE;
          end else begin
            cmd.apply_item = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.apply_rate = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/spg_datapath.sv
// Step timer, position counters, rate divider and result register.
// Depends on spg_pkg; commanded by spg_ctrl.
`timescale 1ns / 1ps

module spg_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spg_pkg::spg_cmd_t                    cmd,
  output spg_pkg::spg_status_t                 status,
  input  logic [1:0]                           in_mode,
  input  logic signed [spg_pkg::RATE_W-1:0]    in_rate_millisteps,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_step_level,
  output logic                                 out_direction_reverse,
  output logic signed [spg_pkg::OUT_POS_W-1:0] out_position_count,
  output logic [spg_pkg::PULSE_W-1:0]          out_total_pulses,
  output logic                                 out_running
);

  // Architectural state
  logic                                     phase_r, phase_nxt;
  logic signed [spg_pkg::RATE_W-1:0]        rate_r, rate_nxt;
  logic [spg_pkg::WHOLE_W-1:0]              whole_r, whole_nxt;
  logic [spg_pkg::FRAC_W-1:0]               frac_r, frac_nxt;
  logic [spg_pkg::ACC_W-1:0]                acc_r, acc_nxt;
  logic [spg_pkg::WIDTH_W-1:0]              width_r, width_nxt;
  logic                                     slow_r, slow_nxt;
  logic [spg_pkg::WHOLE_W-1:0]              count_r, count_nxt;
  logic [spg_pkg::PRESC_W-1:0]              presc_r, presc_nxt;
  logic                                     armed_r, armed_nxt;
  logic                                     step_r, step_nxt;
  logic                                     dir_r, dir_nxt;
  logic [spg_pkg::POSITION_BITS-1:0]        pos_r, pos_nxt;
  logic [spg_pkg::PULSE_W-1:0]              pulses_r, pulses_nxt;

  // Divider
  logic signed [spg_pkg::RATE_W-1:0]        sat_r;
  logic [spg_pkg::MAG_W-1:0]                mag_r;
  logic                                     slow_sel_r;
  logic [spg_pkg::DVD_W-1:0]                dvd_r;
  logic [spg_pkg::MAG_W-1:0]                rem_r;
  logic [spg_pkg::QUOT_W-1:0]               quot_r;
  logic [spg_pkg::DIV_CNT_W-1:0]            div_cnt_r;
  logic [spg_pkg::MAG_W:0]                  rem_sh;
  logic                                     rem_ge;

  // Output register
  logic                                     out_valid_r;
  logic                                     out_step_r;
  logic                                     out_dir_r;
  logic signed [spg_pkg::OUT_POS_W-1:0]     out_pos_r;
  logic [spg_pkg::PULSE_W-1:0]              out_pulses_r;
  logic                                     out_run_r;

  // Input decode
  spg_pkg::mode_t                           mode;
  logic signed [spg_pkg::RATE_W-1:0]        sat_rate;
  logic signed [spg_pkg::RATE_W-1:0]        neg_rate;
  logic [spg_pkg::MAG_W-1:0]                in_mag;

  // Helpers
  logic                                     tick_fire;
  logic [spg_pkg::ACC_W:0]                  acc_sum;
  logic                                     was_running;
  logic [spg_pkg::WHOLE_W-1:0]              new_whole;
  logic [spg_pkg::WIDTH_W-1:0]              new_width;
  logic signed [63:0]                       pos_ext;

  // Saturate the rate and take its magnitude
  assign mode     = spg_pkg::mode_t'(in_mode);
  assign sat_rate = (in_rate_millisteps > spg_pkg::RATE_LIMIT)     ? spg_pkg::RATE_LIMIT :
                    (in_rate_millisteps < spg_pkg::RATE_LIMIT_NEG) ? spg_pkg::RATE_LIMIT_NEG :
                    in_rate_millisteps;
  assign neg_rate = -sat_rate;
  assign in_mag   = sat_rate[spg_pkg::RATE_W-1] ? neg_rate[spg_pkg::MAG_W-1:0]
                                                : sat_rate[spg_pkg::MAG_W-1:0];

  assign status.rate_div = (mode == spg_pkg::MODE_RATE) && (in_mag >= spg_pkg::RATE_STOP_BELOW);
  assign status.div_last = (div_cnt_r == spg_pkg::DIV_CNT_W'(spg_pkg::DIV_STEPS - 1));
  assign status.out_free = !out_valid_r || out_ready;

  // Restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[spg_pkg::DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, mag_r});

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      sat_r      <= sat_rate;
      mag_r      <= in_mag;
      slow_sel_r <= (in_mag < spg_pkg::RATE_SLOW_BELOW);
      dvd_r      <= (in_mag < spg_pkg::RATE_SLOW_BELOW) ? spg_pkg::DVD_SLOW : spg_pkg::DVD_FAST;
      rem_r      <= '0;
      quot_r     <= '0;
      div_cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_ge ? spg_pkg::MAG_W'(rem_sh - {1'b0, mag_r}) : rem_sh[spg_pkg::MAG_W-1:0];
      dvd_r     <= {dvd_r[spg_pkg::DVD_W-2:0], 1'b0};
      quot_r    <= {quot_r[spg_pkg::QUOT_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Timer helpers
  assign tick_fire   = !slow_r || (presc_r == spg_pkg::PRESC_W'(spg_pkg::SLOW_PRESCALE - 1));
  assign acc_sum     = {1'b0, acc_r} + (spg_pkg::ACC_W + 1)'(frac_r);
  assign was_running = (rate_r != '0);
  assign new_whole   = quot_r[spg_pkg::QUOT_W-1:spg_pkg::FRAC_W];
  assign new_width   = slow_sel_r ? spg_pkg::WIDTH_SLOW : spg_pkg::WIDTH_FAST;

  // Next state of the step timer
  always_comb begin
    phase_nxt  = phase_r;
    rate_nxt   = rate_r;
    whole_nxt  = whole_r;
    frac_nxt   = frac_r;
    acc_nxt    = acc_r;
    width_nxt  = width_r;
    slow_nxt   = slow_r;
    count_nxt  = count_r;
    presc_nxt  = presc_r;
    armed_nxt  = armed_r;
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    pos_nxt    = pos_r;
    pulses_nxt = pulses_r;

    if (cmd.apply_item) begin
      unique case (mode)
        spg_pkg::MODE_TICK: begin
          if (slow_r) begin
            presc_nxt = tick_fire ? '0 : presc_r + 1'b1;
          end
          if (tick_fire && armed_r) begin
            if (count_r <= spg_pkg::WHOLE_W'(1)) begin
              // Expiry
              armed_nxt = 1'b0;
              if (!phase_r) begin
                // End of low phase: raise the step pin
                if (was_running) begin
                  step_nxt   = 1'b1;
                  phase_nxt  = 1'b1;
                  dir_nxt    = rate_r[spg_pkg::RATE_W-1];
                  pos_nxt    = rate_r[spg_pkg::RATE_W-1] ? pos_r - 1'b1 : pos_r + 1'b1;
                  pulses_nxt = pulses_r + 1'b1;
                  count_nxt  = spg_pkg::WHOLE_W'(width_r);
                  armed_nxt  = 1'b1;
                end
              end else begin
                // End of high phase: drop the pin, reload with carry
                step_nxt  = 1'b0;
                phase_nxt = 1'b0;
                if (was_running) begin
                  if (acc_sum[spg_pkg::ACC_W-1+1] || acc_sum[spg_pkg::FRAC_W]) begin
                    acc_nxt   = spg_pkg::ACC_W'(acc_sum - (spg_pkg::ACC_W + 1)'(1 << spg_pkg::FRAC_W));
                    count_nxt = whole_r + 1'b1;
                  end else begin
                    acc_nxt   = acc_sum[spg_pkg::ACC_W-1:0];
                    count_nxt = whole_r;
                  end
                  armed_nxt = 1'b1;
                end
              end
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        spg_pkg::MODE_RATE, spg_pkg::MODE_STOP: begin
          // Stop, or a rate too small to run
          rate_nxt = '0;
        end
        spg_pkg::MODE_NOP: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.apply_rate) begin
      rate_nxt  = sat_r;
      whole_nxt = new_whole;
      frac_nxt  = quot_r[spg_pkg::FRAC_W-1:0];
      width_nxt = new_width;
      if (was_running && (slow_sel_r != slow_r)) begin
        // Timebase switch while running: rearm the current phase
        slow_nxt  = slow_sel_r;
        acc_nxt   = '0;
        presc_nxt = '0;
        count_nxt = phase_r ? spg_pkg::WHOLE_W'(new_width) : new_whole;
        armed_nxt = 1'b1;
      end else if (!was_running) begin
        // Start from stopped
        slow_nxt  = slow_sel_r;
        acc_nxt   = '0;
        phase_nxt = 1'b0;
        presc_nxt = '0;
        count_nxt = new_whole;
        armed_nxt = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      rate_r   <= '0;
      whole_r  <= '0;
      frac_r   <= '0;
      acc_r    <= '0;
      width_r  <= '0;
      slow_r   <= 1'b0;
      count_r  <= '0;
      presc_r  <= '0;
      armed_r  <= 1'b0;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
      pos_r    <= '0;
      pulses_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      rate_r   <= rate_nxt;
      whole_r  <= whole_nxt;
      frac_r   <= frac_nxt;
      acc_r    <= acc_nxt;
      width_r  <= width_nxt;
      slow_r   <= slow_nxt;
      count_r  <= count_nxt;
      presc_r  <= presc_nxt;
      armed_r  <= armed_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
      pos_r    <= pos_nxt;
      pulses_r <= pulses_nxt;
    end
  end

  // Position sign-extended from its own width
  assign pos_ext = 64'(signed'(pos_nxt));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply_item || cmd.apply_rate) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_item || cmd.apply_rate) begin
      out_step_r   <= step_nxt;
      out_dir_r    <= dir_nxt;
      out_pos_r    <= pos_ext[spg_pkg::OUT_POS_W-1:0];
      out_pulses_r <= pulses_nxt;
      out_run_r    <= (rate_nxt != '0);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_step_level        = out_step_r;
  assign out_direction_reverse = out_dir_r;
  assign out_position_count    = out_pos_r;
  assign out_total_pulses      = out_pulses_r;
  assign out_running           = out_run_r;

endmodule

>>> rtl/spg_checker.sv
// Port-level checks for the step pulse generator, bound to the top level.
// Depends on spg_pkg and step_pulse_generator.
`timescale 1ns / 1ps

module spg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [1:0]                           in_mode,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_step_level,
  input logic signed [spg_pkg::OUT_POS_W-1:0] out_position_count,
  input logic [spg_pkg::PULSE_W-1:0]          out_total_pulses,
  input logic                                 out_running
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_pulses)
      && $stable(out_position_count) && $stable(out_step_level))
    else $error("stalled result changed");

  // No new item while the result slot is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken with result slot full");

  // A stop shows as not running in the very next result
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == spg_pkg::MODE_STOP) |=> out_valid && !out_running)
    else $error("stop not reflected");

  // A tick gives its result in the next cycle
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == spg_pkg::MODE_TICK) |=> out_valid)
    else $error("tick result missing");

  // Output empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind step_pulse_generator spg_checker u_spg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_mode            (in_mode),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_step_level     (out_step_level),
  .out_position_count (out_position_count),
  .out_total_pulses   (out_total_pulses),
  .out_running        (out_running)
);
